// ----- sv/lph_pkg.sv -----
package lph_pkg;

	localparam logic [7:0] PROTO_UDP     = 8'h11;
	localparam logic [7:0] PROTO_TCP     = 8'h06;
	localparam int         ETH_HDR_LEN   = 14;
	localparam int         IHL_POS       = 14;
	localparam int         PROTO_POS     = 23;
	localparam int         UDP_HDR_LEN   = 8;
	localparam int         TCP_DOFF_REL  = 12;
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

	typedef enum logic [1:0] {
		KIND_UDP   = 2'd0,
		KIND_TCP   = 2'd1,
		KIND_OTHER = 2'd2,
		KIND_TRUNC = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] payload_hash;
		kind_t              packet_kind;
	} result_t;

	// One classified byte on its way from the parser to the hash engine.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       hash_en;
		kind_t      kind;
	} mid_item_t;

	function automatic logic [3:0] clamp_words(input logic [3:0] w);
		clamp_words = (w < MIN_HDR_WORDS) ? MIN_HDR_WORDS : w;
	endfunction

endpackage

// ----- sv/lph_fifo.sv -----
module lph_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	output logic [WIDTH-1:0]         rd_data,
	output logic                     full,
	output logic                     empty,
	output logic [$clog2(DEPTH):0]   level
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + (AW+1)'(1);
				2'b01: count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign level   = count_q;

endmodule

// ----- sv/lph_front.sv -----
module lph_front import lph_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  in_item_t  item,
	output mid_item_t mid_item
);

	localparam int POS_W = $clog2(MAX_PACKET_BYTES);
	localparam int CMP_W = ((POS_W > 8) ? POS_W : 8) + 1;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       proto_q;
	logic [3:0]       ihl_q;
	logic [7:0]       pstart_q;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] len_x;
	logic [3:0]       ihl_n;
	logic [7:0]       proto_n;
	logic [7:0]       pstart_n;
	logic [7:0]       ip_end;
	logic [7:0]       doff_pos;
	logic             is_l4;
	logic             past_proto;
	kind_t            kind;

	always_comb begin
		pos_x      = CMP_W'(pos_q);
		len_x      = pos_x + CMP_W'(1);
		past_proto = (pos_x > CMP_W'(PROTO_POS));

		ihl_n = (pos_x == CMP_W'(IHL_POS)) ? clamp_words(item.data_byte[3:0]) : ihl_q;
		ip_end   = 8'(ETH_HDR_LEN) + {2'b00, ihl_n, 2'b00};
		doff_pos = ip_end + 8'(TCP_DOFF_REL);

		proto_n  = proto_q;
		pstart_n = pstart_q;
		if (pos_x == CMP_W'(PROTO_POS)) begin
			proto_n = item.data_byte;
			if (item.data_byte == PROTO_UDP) begin
				pstart_n = ip_end + 8'(UDP_HDR_LEN);
			end else if (item.data_byte == PROTO_TCP) begin
				pstart_n = ip_end + {2'b00, MIN_HDR_WORDS, 2'b00};
			end else begin
				pstart_n = '0;
			end
		end
		// The TCP data offset sits in the high nibble of TCP header byte 12.
		if (past_proto && proto_n == PROTO_TCP && pos_x == CMP_W'(doff_pos)) begin
			pstart_n = ip_end + {2'b00, clamp_words(item.data_byte[7:4]), 2'b00};
		end

		is_l4 = past_proto && (proto_n == PROTO_UDP || proto_n == PROTO_TCP);

		if (len_x <= CMP_W'(PROTO_POS)) begin
			kind = KIND_TRUNC;
		end else if (proto_n == PROTO_UDP || proto_n == PROTO_TCP) begin
			if (len_x < CMP_W'(pstart_n)) begin
				kind = KIND_TRUNC;
			end else begin
				kind = (proto_n == PROTO_UDP) ? KIND_UDP : KIND_TCP;
			end
		end else begin
			kind = KIND_OTHER;
		end

		mid_item.data_byte = item.data_byte;
		mid_item.last_byte = item.last_byte;
		mid_item.hash_en   = is_l4 && (pos_x >= CMP_W'(pstart_n));
		mid_item.kind      = kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			proto_q  <= '0;
			ihl_q    <= '0;
			pstart_q <= '0;
		end else if (accept) begin
			if (item.last_byte) begin
				pos_q    <= '0;
				proto_q  <= '0;
				ihl_q    <= '0;
				pstart_q <= '0;
			end else begin
				proto_q  <= proto_n;
				ihl_q    <= ihl_n;
				pstart_q <= pstart_n;
				if (pos_q < POS_LIMIT) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

// ----- sv/lph_back.sv -----
module lph_back import lph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mid_item_t mid_item,
	input  logic      mid_empty,
	output logic      mid_pop,
	input  logic      pop,
	output logic      empty,
	output result_t   result
);

	localparam int OUT_DEPTH = 4;
	localparam int LVL_W     = $clog2(OUT_DEPTH) + 1;

	logic [31:0] hash_q;
	logic [31:0] sum1;
	logic [31:0] sum2;
	logic [31:0] hash_upd;

	logic        v_s1, v_s2, v_s3;
	logic [31:0] hash_s1, hash_s2, hash_s3;
	kind_t       kind_s1, kind_s2, kind_s3;

	logic [31:0] mix1;
	logic [31:0] mix2;
	logic [31:0] mix3;
	logic [31:0] abs_hash;
	result_t     res_in;
	logic [$bits(result_t)-1:0] res_out;
	logic [LVL_W-1:0] out_level;
	logic        out_full;
	logic [LVL_W-1:0] pending;
	logic        room;

	// Results already queued plus those still in the mix pipeline must fit.
	always_comb begin
		pending = out_level + LVL_W'(v_s1) + LVL_W'(v_s2) + LVL_W'(v_s3);
		room    = (pending < LVL_W'(OUT_DEPTH));
		mid_pop = !mid_empty && (!mid_item.last_byte || room);
	end

	always_comb begin
		sum1     = hash_q + {24'b0, mid_item.data_byte};
		sum2     = sum1 + (sum1 << 10);
		hash_upd = mid_item.hash_en ? (sum2 ^ 32'($signed(sum2) >>> 6)) : hash_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (mid_pop) begin
				hash_q <= mid_item.last_byte ? '0 : hash_upd;
			end
			v_s1 <= mid_pop && mid_item.last_byte;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		mix1 = hash_s1 + (hash_s1 << 3);
		mix2 = mix1 ^ 32'($signed(mix1) >>> 11);
		mix3 = hash_s2 + (hash_s2 << 15);
		// The negation of the most negative value wraps back onto itself.
		abs_hash = hash_s3[31] ? (32'd0 - hash_s3) : hash_s3;
		res_in.packet_kind  = kind_s3;
		res_in.payload_hash = (kind_s3 == KIND_UDP || kind_s3 == KIND_TCP) ? abs_hash : '0;
	end

	always_ff @(posedge clk) begin
		hash_s1 <= hash_upd;
		kind_s1 <= mid_item.kind;
		hash_s2 <= mix2;
		kind_s2 <= kind_s1;
		hash_s3 <= mix3;
		kind_s3 <= kind_s2;
	end

	lph_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (v_s3),
		.wr_data (res_in),
		.rd_en   (pop && !empty),
		.rd_data (res_out),
		.full    (out_full),
		.empty   (empty),
		.level   (out_level)
	);

	always_comb begin
		result = res_out;
		if (out_full && v_s3) begin
			result = res_out;
		end
	end

endmodule

// ----- sv/l4_payload_oat_hash.sv -----
// Payload hash of Ethernet/IPv4 frames fed one byte per transaction, destination
// address first, with last_byte marking the final byte. The parser finds the UDP or
// TCP payload from the IHL, the protocol byte and the TCP data offset, and the hash
// engine runs a one-at-a-time hash with arithmetic right shifts over the payload
// bytes. One result per frame comes out of the result queue: the absolute value of
// the mixed hash and the kind (udp, tcp, other protocol, or truncated headers, the
// last two with hash 0). A byte is taken every cycle while the byte queue is not
// full; the per-byte hash update is a combinational loop on the running hash. A
// frame's last byte waits in the byte queue until the result queue has room, then
// passes the mix pipeline registers s1, s2 and s3; the last one writes the result
// queue. Frames longer than MAX_PACKET_BYTES keep hashing with the position held.
module l4_payload_oat_hash import lph_pkg::*; #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     empty,
	input  logic     pop,
	output result_t  result
);

	localparam int MID_DEPTH = 4;

	mid_item_t front_item;
	mid_item_t back_item;
	logic [$bits(mid_item_t)-1:0] back_bits;
	logic      mid_empty;
	logic      mid_pop;
	logic      accept;
	logic [$clog2(MID_DEPTH):0] mid_level;

	assign accept    = push && !full;
	assign back_item = back_bits;

	lph_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.mid_item (front_item)
	);

	lph_fifo #(
		.WIDTH($bits(mid_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (front_item),
		.rd_en   (mid_pop),
		.rd_data (back_bits),
		.full    (full),
		.empty   (mid_empty),
		.level   (mid_level)
	);

	lph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_item  (back_item),
		.mid_empty (mid_empty || (mid_level == '0)),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
